@@ hw/rtl/csb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the coprocessor slice budget block.
// Holds the word structs, codes, state enum and constants; no dependencies.
package csb_pkg;

   localparam int unsigned ClockRate     = 5823405;
   localparam int unsigned PalDivisor    = 50 * 312;
   localparam int unsigned NtscDivisor   = 60 * 262;
   localparam int unsigned PalSlow       = ClockRate / PalDivisor;
   localparam int unsigned NtscSlow      = ClockRate / NtscDivisor;
   localparam int unsigned PalFast       = PalSlow * 5 / 2;
   localparam int unsigned NtscFast      = NtscSlow * 5 / 2;

   localparam int unsigned BANK_LINES_DEF = 240;

   localparam int unsigned MUL_W    = 20;
   localparam int unsigned BUDGET_W = 13;
   localparam int unsigned GRANT_W  = 21;
   localparam int unsigned PCT_W    = 10;
   localparam int unsigned BASE_W   = 10;

   // x / 100 == (x * RecipHundred) >> RecipShift for x below 2^26 / 36
   localparam int unsigned RecipShift   = 26;
   localparam int unsigned RecipHundred = ((1 << RecipShift) + 99) / 100;

   localparam logic [GRANT_W-1:0] GRANT_MAX = '1;

   localparam logic [PCT_W-1:0] PCT_LOW     = 10'd50;
   localparam logic [PCT_W-1:0] PCT_HIGH    = 10'd800;
   localparam logic [PCT_W-1:0] PCT_DEFAULT = 10'd100;

   localparam logic [6:0] ROM_BANK_LIMIT = 7'h70;
   localparam int unsigned GATE_ROM_BIT  = 4;
   localparam int unsigned GATE_RAM_BIT  = 3;
   localparam int unsigned STAT_GO_BIT   = 5;
   localparam int unsigned STAT_IRQ_BIT  = 15;
   localparam int unsigned CFG_MASK_BIT  = 7;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIDEO_IS_PAL  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_PERCENT = 1'd1;

   typedef enum logic [1:0] {
      FUNC_SCANLINE = 2'd0,
      FUNC_GO       = 2'd1,
      FUNC_VBLANK   = 2'd2,
      FUNC_STATUS   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSB_IDLE,
      CSB_SCALE,
      CSB_RECIP,
      CSB_CAP,
      CSB_RESOLVE
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  screen_mode;
      logic [7:0]  program_bank;
      logic [15:0] status_word;
      logic [7:0]  config_word;
      logic        fast_clock;
   } req_word_type;

   typedef struct packed {
      logic               run_now;
      logic [GRANT_W-1:0] opcode_budget;
      logic               raise_irq;
   } rsp_word_type;

   function automatic logic [BASE_W-1:0] base_budget(input logic pal, input logic fast);
      logic [BASE_W-1:0] b;
      unique case ({pal, fast})
         2'b00:   b = BASE_W'(NtscSlow);
         2'b01:   b = BASE_W'(NtscFast);
         2'b10:   b = BASE_W'(PalSlow);
         default: b = BASE_W'(PalFast);
      endcase
      return b;
   endfunction

   function automatic logic gate_open(input logic [7:0] mode, input logic [7:0] bank);
      logic rom;
      rom = (bank[6:0] < ROM_BANK_LIMIT);
      return rom ? mode[GATE_ROM_BIT] : mode[GATE_RAM_BIT];
   endfunction

endpackage

@@ hw/rtl/csb_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on csb_pkg for the payload structs.
interface csb_req_if;
   logic                  valid;
   logic                  ready;
   csb_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface csb_rsp_if;
   logic                  valid;
   logic                  ready;
   csb_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/coprocessor_slice_budget.sv @@
`timescale 1ns / 1ps
// Coprocessor slice budget: grants an instruction budget per video event.
// Depends on csb_pkg and the channel interfaces in csb_if.sv.
//
//   channel    dir  handshake      word
//   req_chan   in   valid/ready    func, screen_mode, program_bank, status_word, ...
//   rsp_chan   out  valid/ready    run_now, opcode_budget, raise_irq
//   csr_*      in   write enable   video_is_pal (0), clock_percent (1)
//
// Each word is accepted, then steps through four sequencer states (scale by percent,
// divide by 100, line cap, resolve); all but resolve use the shared multiplier.
// Ready only while idle. The resolve step waits while the output register is full.
// Synchronous active-high reset sets config to NTSC and the default percent, and clears banked budget and control.
module coprocessor_slice_budget #(
   parameter int unsigned BANK_LINES = csb_pkg::BANK_LINES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [csb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [csb_pkg::CSR_DATA_W-1:0]      csr_wdata,
   csb_req_if.sink                             req_chan,
   csb_rsp_if.source                           rsp_chan
);

   localparam int unsigned MW = csb_pkg::MUL_W;
   localparam int unsigned BW = csb_pkg::BUDGET_W;
   localparam int unsigned GW = csb_pkg::GRANT_W;

   csb_pkg::state_type state_ff, state_in;

   logic                        pal_ff;
   logic [csb_pkg::PCT_W-1:0]   pct_ff;
   logic                        slice_run_ff, slice_run_in;
   logic [GW-1:0]               owed_ff, owed_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   csb_pkg::rsp_word_type       rsp_word_ff, rsp_word_in;

   csb_pkg::func_type           func_ff, func_in;
   logic                        gate_ff, gate_in;
   logic                        go_ff, go_in;
   logic                        irqf_ff, irqf_in;
   logic                        mask_ff, mask_in;
   logic                        fast_ff, fast_in;
   logic [MW-1:0]               prod_ff, prod_in;
   logic [BW-1:0]               budget_ff, budget_in;
   logic [GW-1:0]               cap_ff, cap_in;

   logic [MW-1:0]               mul_a, mul_b;
   logic [2*MW-1:0]             mul_p;
   logic [csb_pkg::PCT_W-1:0]   pct_eff;
   logic [GW:0]                 owed_sum;

   assign mul_p = mul_a * mul_b;
   assign pct_eff = (pct_ff < csb_pkg::PCT_LOW || pct_ff > csb_pkg::PCT_HIGH)
                    ? csb_pkg::PCT_DEFAULT : pct_ff;
   assign owed_sum = {1'b0, owed_ff} + (GW+1)'(budget_ff);

   assign req_chan.ready = (state_ff == csb_pkg::CSB_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csb_pkg::CSB_IDLE;
         pal_ff       <= 1'b0;
         pct_ff       <= csb_pkg::PCT_DEFAULT;
         slice_run_ff <= 1'b0;
         owed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slice_run_ff <= slice_run_in;
         owed_ff      <= owed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               csb_pkg::CSR_VIDEO_IS_PAL:  pal_ff <= csr_wdata[0];
               csb_pkg::CSR_CLOCK_PERCENT: pct_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      func_ff     <= func_in;
      gate_ff     <= gate_in;
      go_ff       <= go_in;
      irqf_ff     <= irqf_in;
      mask_ff     <= mask_in;
      fast_ff     <= fast_in;
      prod_ff     <= prod_in;
      budget_ff   <= budget_in;
      cap_ff      <= cap_in;
   end

   always_comb begin
      state_in     = state_ff;
      slice_run_in = slice_run_ff;
      owed_in      = owed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      func_in      = func_ff;
      gate_in      = gate_ff;
      go_in        = go_ff;
      irqf_in      = irqf_ff;
      mask_in      = mask_ff;
      fast_in      = fast_ff;
      prod_in      = prod_ff;
      budget_in    = budget_ff;
      cap_in       = cap_ff;
      mul_a        = '0;
      mul_b        = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         csb_pkg::CSB_IDLE: begin
            if (req_chan.valid) begin
               func_in  = csb_pkg::func_type'(req_chan.data.func);
               gate_in  = csb_pkg::gate_open(req_chan.data.screen_mode,
                                             req_chan.data.program_bank);
               go_in    = req_chan.data.status_word[csb_pkg::STAT_GO_BIT];
               irqf_in  = req_chan.data.status_word[csb_pkg::STAT_IRQ_BIT];
               mask_in  = req_chan.data.config_word[csb_pkg::CFG_MASK_BIT];
               fast_in  = req_chan.data.fast_clock;
               state_in = csb_pkg::CSB_SCALE;
            end
         end
         csb_pkg::CSB_SCALE: begin
            mul_a    = MW'(csb_pkg::base_budget(pal_ff, fast_ff));
            mul_b    = MW'(pct_eff);
            prod_in  = mul_p[MW-1:0];
            state_in = csb_pkg::CSB_RECIP;
         end
         csb_pkg::CSB_RECIP: begin
            mul_a     = prod_ff;
            mul_b     = MW'(csb_pkg::RecipHundred);
            budget_in = mul_p[csb_pkg::RecipShift +: BW];
            state_in  = csb_pkg::CSB_CAP;
         end
         csb_pkg::CSB_CAP: begin
            mul_a    = MW'(budget_ff);
            mul_b    = MW'(BANK_LINES);
            cap_in   = (mul_p > (2*MW)'(csb_pkg::GRANT_MAX)) ? csb_pkg::GRANT_MAX
                                                             : mul_p[GW-1:0];
            state_in = csb_pkg::CSB_RESOLVE;
         end
         csb_pkg::CSB_RESOLVE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_word_in = '0;
               unique case (func_ff)
                  csb_pkg::FUNC_SCANLINE: begin
                     if (slice_run_ff) begin
                        slice_run_in = 1'b0;
                     end else if (gate_ff) begin
                        rsp_word_in.run_now       = 1'b1;
                        rsp_word_in.opcode_budget = owed_sum[GW] ? csb_pkg::GRANT_MAX
                                                                 : owed_sum[GW-1:0];
                        owed_in = '0;
                     end else begin
                        owed_in = (owed_sum > {1'b0, cap_ff}) ? cap_ff : owed_sum[GW-1:0];
                     end
                  end
                  csb_pkg::FUNC_GO: begin
                     if (gate_ff) begin
                        rsp_word_in.run_now       = 1'b1;
                        rsp_word_in.opcode_budget = GW'(budget_ff);
                        slice_run_in              = 1'b1;
                     end
                  end
                  csb_pkg::FUNC_VBLANK: begin
                     if (go_ff && gate_ff) begin
                        rsp_word_in.run_now       = 1'b1;
                        rsp_word_in.opcode_budget = cap_ff;
                     end
                  end
                  default: begin
                     rsp_word_in.raise_irq = irqf_ff && !go_ff && !mask_ff;
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = csb_pkg::CSB_IDLE;
            end
         end
         default: begin
            state_in = csb_pkg::CSB_IDLE;
         end
      endcase
   end

   a_rsp_from_resolve: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == csb_pkg::CSB_RESOLVE))
      else $error("response word raised outside resolve step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == csb_pkg::CSB_SCALE))
      else $error("accepted word did not start the sequencer");

   a_slice_flag_go: assert property (@(posedge clock) disable iff (reset)
      $rose(slice_run_ff) |-> $past(func_ff == csb_pkg::FUNC_GO && gate_ff))
      else $error("slice flag set by an event other than an open-gate go start");

   a_idle_run_budget: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.run_now) |-> (rsp_word_ff.opcode_budget == '0))
      else $error("nonzero budget on a word that runs nothing");

endmodule

@@ verif/coprocessor_slice_budget_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for coprocessor_slice_budget: a directed event table, then random
// events over several video/clock settings; words checked against table rows or a budget model.
// Depends on csb_pkg, the channel interfaces in csb_if.sv and the block's RTL.
module coprocessor_slice_budget_test;

   localparam int unsigned BANK_LINES = 240;
   localparam int unsigned LINE_CLOCK = 5823405;
   localparam int unsigned PAL_RATE   = 50 * 312;
   localparam int unsigned NTSC_RATE  = 60 * 262;
   localparam logic [csb_pkg::GRANT_W-1:0] GRANT_SAT = '1;
   localparam int unsigned REQ_W      = $bits(csb_pkg::req_word_type);
   localparam int unsigned N_DIRECTED = 24;
   localparam int unsigned N_PHASES   = 11;

   typedef struct {
      csb_pkg::req_word_type word;
      bit                    typed;
      csb_pkg::rsp_word_type want;
   } stim_row_type;

   typedef struct {
      logic        pal;
      logic [9:0]  pct;
      int unsigned words;
      int unsigned open_pct;
      int unsigned line_pct;
   } phase_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write;
   logic [csb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [csb_pkg::CSR_DATA_W-1:0]  csr_wdata;

   csb_req_if req_chan();
   csb_rsp_if rsp_chan();

   // budget model state
   logic        cfg_pal;
   logic [9:0]  cfg_pct;
   logic        go_ran;
   logic [63:0] owed;

   csb_pkg::rsp_word_type grant_queue[$];
   int unsigned  errors = 0;
   int unsigned  send_quiet = 0;
   int unsigned  recv_quiet = 0;
   int unsigned  stall_left = 0;
   stim_row_type stim_table [N_DIRECTED];
   phase_type    phases [N_PHASES];

   coprocessor_slice_budget #(
      .BANK_LINES(BANK_LINES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("coprocessor_slice_budget: mismatch");
      $finish;
   end

   function automatic logic [63:0] line_budget(input logic fast);
      logic [63:0] per;
      logic [63:0] b;
      logic [63:0] pct;
      per = LINE_CLOCK / (cfg_pal ? PAL_RATE : NTSC_RATE);
      b = fast ? per * 5 / 2 : per;
      pct = (cfg_pct < 50 || cfg_pct > 800) ? 64'd100 : 64'(cfg_pct);
      return b * pct / 100;
   endfunction

   function automatic logic [csb_pkg::GRANT_W-1:0] clip_grant(input logic [63:0] v);
      return (v > 64'(GRANT_SAT)) ? GRANT_SAT : v[csb_pkg::GRANT_W-1:0];
   endfunction

   function automatic csb_pkg::rsp_word_type predict_slice(input csb_pkg::req_word_type w);
      csb_pkg::rsp_word_type r;
      logic [63:0]  budget;
      logic [63:0]  sum;
      logic [63:0]  cap;
      logic         gate;
      r = '0;
      budget = line_budget(w.fast_clock);
      gate = (w.program_bank[6:0] < csb_pkg::ROM_BANK_LIMIT)
             ? w.screen_mode[csb_pkg::GATE_ROM_BIT] : w.screen_mode[csb_pkg::GATE_RAM_BIT];
      case (w.func)
         csb_pkg::FUNC_SCANLINE: begin
            if (go_ran) begin
               go_ran = 1'b0;
            end else if (gate) begin
               r.run_now = 1'b1;
               r.opcode_budget = clip_grant(budget + owed);
               owed = 0;
            end else begin
               cap = budget * BANK_LINES;
               sum = owed + budget;
               if (sum > cap) sum = cap;
               owed = 64'(clip_grant(sum));
            end
         end
         csb_pkg::FUNC_GO: begin
            if (gate) begin
               r.run_now = 1'b1;
               r.opcode_budget = clip_grant(budget);
               go_ran = 1'b1;
            end
         end
         csb_pkg::FUNC_VBLANK: begin
            if (w.status_word[csb_pkg::STAT_GO_BIT] && gate) begin
               r.run_now = 1'b1;
               r.opcode_budget = clip_grant(budget * BANK_LINES);
            end
         end
         default: begin
            r.raise_irq = w.status_word[csb_pkg::STAT_IRQ_BIT]
                          && !w.status_word[csb_pkg::STAT_GO_BIT]
                          && !w.config_word[csb_pkg::CFG_MASK_BIT];
         end
      endcase
      return r;
   endfunction

   function automatic stim_row_type stim_row(input csb_pkg::func_type f,
                                             input logic [7:0] mode,
                                             input logic [7:0] bank, input logic [15:0] status,
                                             input logic [7:0] cfg, input logic fast,
                                             input bit typed, input logic run,
                                             input logic [csb_pkg::GRANT_W-1:0] grant,
                                             input logic irq);
      stim_row_type s;
      s.word.func = f;
      s.word.screen_mode = mode;
      s.word.program_bank = bank;
      s.word.status_word = status;
      s.word.config_word = cfg;
      s.word.fast_clock = fast;
      s.typed = typed;
      s.want.run_now = run;
      s.want.opcode_budget = grant;
      s.want.raise_irq = irq;
      return s;
   endfunction

   function automatic csb_pkg::req_word_type random_word(input int unsigned open_pct,
                                                         input int unsigned line_pct);
      csb_pkg::req_word_type w;
      logic                  open;
      w = REQ_W'({$urandom, $urandom});
      if ($urandom_range(0, 99) < line_pct) w.func = csb_pkg::FUNC_SCANLINE;
      else w.func = 2'($urandom_range(1, 3));
      open = $urandom_range(0, 99) < open_pct;
      if (w.program_bank[6:0] < csb_pkg::ROM_BANK_LIMIT)
         w.screen_mode[csb_pkg::GATE_ROM_BIT] = open;
      else w.screen_mode[csb_pkg::GATE_RAM_BIT] = open;
      return w;
   endfunction

   // mostly short gaps, a few long ones, and occasional runs with none
   function automatic int unsigned pick_gap(inout int unsigned quiet);
      int unsigned r;
      if (quiet != 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         quiet = $urandom_range(10, 40);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input csb_pkg::req_word_type w, input bit typed,
                            input csb_pkg::rsp_word_type want);
      int unsigned           gap;
      csb_pkg::rsp_word_type predicted;
      gap = pick_gap(send_quiet);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= w;
      do @(posedge clock); while (!req_chan.ready);
      predicted = predict_slice(w);
      grant_queue.push_back(typed ? want : predicted);
   endtask

   task automatic drain_grants();
      req_chan.valid <= 1'b0;
      while (grant_queue.size() != 0) @(posedge clock);
   endtask

   task automatic program_config(input logic pal, input logic [9:0] pct);
      drain_grants();
      csr_write <= 1'b1;
      csr_index <= csb_pkg::CSR_VIDEO_IS_PAL;
      csr_wdata <= csb_pkg::CSR_DATA_W'({$urandom, pal});
      @(posedge clock);
      csr_index <= csb_pkg::CSR_CLOCK_PERCENT;
      csr_wdata <= pct;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_pal = pal;
      cfg_pct = pct;
   endtask

   task automatic check_grant(input csb_pkg::rsp_word_type got);
      csb_pkg::rsp_word_type want;
      if (grant_queue.size() == 0) begin
         $error("unexpected word: run_now %0d opcode_budget %0d raise_irq %0d",
                got.run_now, got.opcode_budget, got.raise_irq);
         errors++;
         return;
      end
      want = grant_queue.pop_front();
      if (got.run_now !== want.run_now) begin
         $error("run_now: expected %0d, got %0d", want.run_now, got.run_now);
         errors++;
      end
      if (got.opcode_budget !== want.opcode_budget) begin
         $error("opcode_budget: expected %0d, got %0d", want.opcode_budget, got.opcode_budget);
         errors++;
      end
      if (got.raise_irq !== want.raise_irq) begin
         $error("raise_irq: expected %0d, got %0d", want.raise_irq, got.raise_irq);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_grant(rsp_chan.data);
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap(recv_quiet);
         end
      end
   end

   initial begin
      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.data <= '0;
      cfg_pal = 1'b0;
      cfg_pct = 10'd100;
      go_ran = 1'b0;
      owed = 0;

      // reset settings: NTSC, 100 percent -> 370 per line, 925 fast
      stim_table = '{
         stim_row(csb_pkg::FUNC_SCANLINE, 8'h10, 8'h00, 16'h0000, 8'h00, 1'b0, 1,
                  1'b1, 21'd370, 1'b0),
         stim_row(csb_pkg::FUNC_STATUS,   8'h00, 8'h00, 16'h8000, 8'h00, 1'b0, 1,
                  1'b0, 21'd0,   1'b1),
         stim_row(csb_pkg::FUNC_STATUS,   8'h00, 8'h00, 16'h8020, 8'h00, 1'b0, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_STATUS,   8'h00, 8'h00, 16'h8000, 8'h80, 1'b0, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_STATUS,   8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_STATUS,   8'h00, 8'h00, 16'h7FDF, 8'h7F, 1'b0, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_GO,       8'hEF, 8'h00, 16'h0000, 8'h00, 1'b0, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_GO,       8'h10, 8'h6F, 16'h0000, 8'h00, 1'b0, 1,
                  1'b1, 21'd370, 1'b0),
         stim_row(csb_pkg::FUNC_SCANLINE, 8'hFF, 8'h00, 16'h0000, 8'h00, 1'b0, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_SCANLINE, 8'h08, 8'h6F, 16'h0000, 8'h00, 1'b0, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_SCANLINE, 8'h08, 8'h70, 16'h0000, 8'h00, 1'b1, 0,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_SCANLINE, 8'hF7, 8'hF0, 16'h0000, 8'h00, 1'b1, 0,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_SCANLINE, 8'hE7, 8'h7F, 16'h0000, 8'h00, 1'b0, 0,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_SCANLINE, 8'h18, 8'hFF, 16'h0000, 8'h00, 1'b0, 0,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_VBLANK,   8'h10, 8'h80, 16'h0020, 8'h00, 1'b0, 1,
                  1'b1, 21'd88800, 1'b0),
         stim_row(csb_pkg::FUNC_VBLANK,   8'hFF, 8'h00, 16'hFFDF, 8'h00, 1'b0, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_VBLANK,   8'hEF, 8'h00, 16'hFFFF, 8'h00, 1'b1, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_VBLANK,   8'h08, 8'hFF, 16'h0020, 8'h00, 1'b1, 0,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_GO,       8'h18, 8'hEF, 16'h0000, 8'h00, 1'b1, 0,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_VBLANK,   8'hFF, 8'h00, 16'hFFFF, 8'h00, 1'b0, 0,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_SCANLINE, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_SCANLINE, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_GO,       8'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 1,
                  1'b0, 21'd0,   1'b0),
         stim_row(csb_pkg::FUNC_SCANLINE, 8'h10, 8'h00, 16'h0000, 8'h00, 1'b0, 0,
                  1'b0, 21'd0,   1'b0)
      };

      // gate held shut for a long stretch drives the bank into its cap
      phases = '{
         '{1'b0, 10'd100,  80, 50, 50},
         '{1'b1, 10'd800,  80, 50, 50},
         '{1'b0, 10'd50,   80, 50, 50},
         '{1'b1, 10'd49,   80, 50, 50},
         '{1'b0, 10'd801,  80, 50, 50},
         '{1'b1, 10'd1023, 80, 50, 50},
         '{1'b0, 10'd0,    80, 50, 50},
         '{1'b1, 10'd800, 300,  0, 92},
         '{1'b1, 10'd800,  80, 50, 50},
         '{1'($urandom), 10'($urandom_range(50, 800)), 80, 50, 50},
         '{1'($urandom), 10'($urandom), 80, 50, 50}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) send_word(stim_table[i].word, stim_table[i].typed,
                                        stim_table[i].want);

      foreach (phases[p]) begin
         program_config(phases[p].pal, phases[p].pct);
         repeat (phases[p].words)
            send_word(random_word(phases[p].open_pct, phases[p].line_pct), 1'b0, '0);
      end

      drain_grants();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("coprocessor_slice_budget: match");
      else $display("coprocessor_slice_budget: mismatch");
      $finish;
   end

endmodule
